>>> hw/rtl/ftach_pkg.sv
`default_nettype none
package ftach_pkg;

  localparam int TIME_W    = 32;
  localparam int RPM_W     = 15;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int STEP_W    = $clog2(RPM_W + 1);

  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [RPM_W-1:0]     rpm_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [STEP_W-1:0]    step_t;

  localparam cfg_idx_t  CFG_DEBOUNCE = 1'b0;
  localparam cfg_idx_t  CFG_STUCK    = 1'b1;

  localparam cfg_data_t DEBOUNCE_RESET = 16'd0;
  localparam cfg_data_t STUCK_RESET    = 16'd500;

  // Two pulses per revolution: (60000 / p) / 2 equals 30000 / p.
  localparam int   MS_PER_MINUTE  = 60000;
  localparam int   PULSES_PER_REV = 2;
  localparam rpm_t RPM_DIVIDEND   = RPM_W'(MS_PER_MINUTE / PULSES_PER_REV);
  localparam step_t DIV_STEPS     = STEP_W'(RPM_W);

endpackage
`default_nettype wire

>>> hw/rtl/ftach_if.sv
`default_nettype none
interface ftach_in_if;
  import ftach_pkg::*;

  logic  valid;
  logic  ready;
  logic  cmd;
  time_t now_ms;

  modport source (output valid, output cmd, output now_ms, input ready);
  modport sink (input valid, input cmd, input now_ms, output ready);
endinterface

interface ftach_out_if;
  import ftach_pkg::*;

  logic valid;
  logic ready;
  rpm_t rpm;

  modport source (output valid, output rpm, input ready);
  modport sink (input valid, input rpm, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ftach_div.sv
`default_nettype none
module ftach_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire ftach_pkg::rpm_t divisor,
  output logic                done,
  output ftach_pkg::rpm_t     quotient
);
  import ftach_pkg::*;

  logic          busy;
  step_t         count;
  rpm_t          dividend;
  rpm_t          rem;
  rpm_t          dvs;
  logic [RPM_W:0] trial;
  logic [RPM_W:0] diff;
  logic           fits;

  // Restoring division, one quotient bit per cycle, dividend bits enter MSB first.
  assign trial = {rem, dividend[RPM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= DIV_STEPS;
      end else if (busy) begin
        count <= count - step_t'(1);
        if (count == step_t'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= RPM_DIVIDEND;
      rem      <= '0;
      quotient <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      dividend <= {dividend[RPM_W-2:0], 1'b0};
      rem      <= fits ? diff[RPM_W-1:0] : trial[RPM_W-1:0];
      quotient <= {quotient[RPM_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/fan_tach_rpm_meter.sv
// Fan tachometer that reports fan speed in RPM.
// Input channel tach_in carries cmd (1 = tach pulse edge, 0 = query) and
// now_ms, the free-running millisecond time. Every transfer on tach_in gives
// exactly one transfer on rpm_out carrying rpm.
// A pulse is taken when more than debounce_ms has passed since the last
// accepted pulse; on each transfer the period between the last two pulses is
// divided into 30000 by a bit-serial restoring divider, one quotient bit per cycle.
// The result is 0 instead when no pulse was taken yet, when stuck_ms has passed
// since the last pulse, or when the period is 0 or above 30000.
// One item is in work at a time: it passes the DEB, EVAL and PER states, the
// divider when a division runs, and the DONE state, and tach_in is ready
// again only once its result is in the output register.
// The result sits in an output register, so a new item is taken while the
// previous result waits; when the receiver stalls longer, a finished result
// waits inside the block and tach_in stays not ready.
// The user must write registers through cfg_we, cfg_index and cfg_data only while idle; the block does not enforce it.
// Reset clears both pulse times, sets debounce_ms to 0 and stuck_ms to 500.
`default_nettype none
module fan_tach_rpm_meter (
  input  wire logic                clk,
  input  wire logic                rst,
  ftach_in_if.sink                 tach_in,
  ftach_out_if.source              rpm_out,
  input  wire logic                cfg_we,
  input  wire ftach_pkg::cfg_idx_t cfg_index,
  input  wire ftach_pkg::cfg_data_t cfg_data
);
  import ftach_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEB  = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_PER  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  cfg_data_t  debounce_ms;
  cfg_data_t  stuck_ms;
  time_t      older;
  time_t      newer;
  logic       cmd;
  time_t      now_ms;
  logic       stopped;
  rpm_t       result;
  logic       out_valid;
  rpm_t       out_rpm;
  time_t      elapsed;
  time_t      period;
  logic       too_long;
  logic       div_start;
  logic       div_done;
  rpm_t       quotient;
  logic       out_load;

  assign elapsed  = now_ms - newer;
  assign period   = newer - older;
  assign too_long = period > time_t'(RPM_DIVIDEND);
  assign out_load = (state == ST_DONE) && (!out_valid || rpm_out.ready);
  assign div_start = (state == ST_PER) && !stopped && (period != '0) && !too_long;

  assign tach_in.ready = (state == ST_IDLE);
  assign rpm_out.valid = out_valid;
  assign rpm_out.rpm   = out_rpm;

  ftach_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (period[RPM_W-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (tach_in.valid) state_next = ST_DEB;
      ST_DEB:  state_next = ST_EVAL;
      ST_EVAL: state_next = ST_PER;
      ST_PER:  state_next = div_start ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_done) state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      debounce_ms <= DEBOUNCE_RESET;
      stuck_ms    <= STUCK_RESET;
      older       <= '0;
      newer       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE: debounce_ms <= cfg_data;
          CFG_STUCK:    stuck_ms    <= cfg_data;
          default:      ;
        endcase
      end
      if (state == ST_DEB && cmd && elapsed > time_t'(debounce_ms)) begin
        older <= newer;
        newer <= now_ms;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rpm_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && tach_in.valid) begin
      cmd    <= tach_in.cmd;
      now_ms <= tach_in.now_ms;
    end
    if (state == ST_EVAL) begin
      stopped <= (newer == '0) || (elapsed >= time_t'(stuck_ms));
    end
    if (state == ST_PER) begin
      result <= '0;
    end else if (state == ST_DIV && div_done) begin
      result <= quotient;
    end
    if (out_load) begin
      out_rpm <= result;
    end
  end
endmodule
`default_nettype wire
